// File: rtl/ami_pkg.sv
// Shared constants and width helpers for the affine matrix inverse block.
package ami_pkg;

    // Default element format: signed Q16.16 in 32 bits.
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Front-end multiply schedule: nine adjugate entries, three determinant
    // terms, then nine translation terms.
    localparam int STEP_DET  = 9;
    localparam int STEP_TR   = 12;
    localparam int STEP_LAST = 20;

    // Result row codes.
    localparam logic [1:0] ROW0     = 2'd0;
    localparam logic [1:0] ROW1     = 2'd1;
    localparam logic [1:0] ROW2     = 2'd2;
    localparam logic [1:0] LAST_ROW = ROW2;

    // Width of one adjugate entry (difference of two element products).
    function automatic int f_adj_w(input int w);
        return 2 * w + 1;
    endfunction

    // Width of the determinant and translation accumulators.
    function automatic int f_acc_w(input int w);
        return 3 * w + 3;
    endfunction

    // Width of one queued request: nine adjugate entries, the determinant,
    // three translation sums and the singular flag.
    function automatic int f_job_w(input int w);
        return 9 * f_adj_w(w) + 4 * f_acc_w(w) + 1;
    endfunction

endpackage

// File: rtl/ami_front.sv
// Front end: accepts a transform and forms its adjugate, determinant and translation sums.
module ami_front import ami_pkg::*; #(
    parameter int W = ELEM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [W-1:0]           i_m [9],
    input  logic signed [W-1:0]           i_t [3],
    output logic                          o_push,
    output logic [f_job_w(W)-1:0]         o_job,
    input  logic                          i_full
);

    localparam int MW = W + 1;
    localparam int PW = 2 * MW;
    localparam int AW = f_adj_w(W);
    localparam int CW = f_acc_w(W);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_RUN   = 4'b0010,
        F_DRAIN = 4'b0100,
        F_PUSH  = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [4:0] r_step, n_step;
    logic signed [W-1:0]  r_m [9];
    logic signed [W-1:0]  r_t [3];
    logic signed [PW-1:0] r_pa, r_pb;
    logic [4:0]           r_pstep;
    logic                 r_pv;
    logic signed [AW-1:0] r_adj [9];
    logic signed [CW-1:0] r_det;
    logic signed [CW-1:0] r_tr [3];

    logic signed [W-1:0]  s_a0, s_a1, s_b0, s_b1, s_x;
    logic signed [AW-1:0] s_adj;
    logic signed [MW-1:0] s_opa_x, s_opa_y, s_opb_x, s_opb_y;
    logic signed [PW-1:0] s_diff;
    logic signed [CW-1:0] s_val;
    logic                 s_accept;

    assign s_accept = i_start && (r_state == F_IDLE);
    assign o_busy   = (r_state != F_IDLE);
    assign o_push   = (r_state == F_PUSH) && !i_full;

    // Control sequencer.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            F_IDLE: begin
                n_step = '0;
                if (i_start) begin
                    n_state = F_RUN;
                end
            end
            F_RUN: begin
                if (r_step == 5'(STEP_LAST)) begin
                    n_state = F_DRAIN;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            F_DRAIN: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pv    <= (r_state == F_RUN);
        end
    end

    // Operand selection for each scheduled step.
    always_comb begin
        s_a0  = r_m[0];
        s_a1  = r_m[0];
        s_b0  = r_m[0];
        s_b1  = r_m[0];
        s_x   = r_m[0];
        s_adj = r_adj[0];
        case (r_step)
            5'd0:  begin s_a0 = r_m[4]; s_a1 = r_m[8]; s_b0 = r_m[5]; s_b1 = r_m[7]; end
            5'd1:  begin s_a0 = r_m[7]; s_a1 = r_m[2]; s_b0 = r_m[8]; s_b1 = r_m[1]; end
            5'd2:  begin s_a0 = r_m[1]; s_a1 = r_m[5]; s_b0 = r_m[2]; s_b1 = r_m[4]; end
            5'd3:  begin s_a0 = r_m[5]; s_a1 = r_m[6]; s_b0 = r_m[3]; s_b1 = r_m[8]; end
            5'd4:  begin s_a0 = r_m[8]; s_a1 = r_m[0]; s_b0 = r_m[6]; s_b1 = r_m[2]; end
            5'd5:  begin s_a0 = r_m[2]; s_a1 = r_m[3]; s_b0 = r_m[0]; s_b1 = r_m[5]; end
            5'd6:  begin s_a0 = r_m[3]; s_a1 = r_m[7]; s_b0 = r_m[4]; s_b1 = r_m[6]; end
            5'd7:  begin s_a0 = r_m[6]; s_a1 = r_m[1]; s_b0 = r_m[7]; s_b1 = r_m[0]; end
            5'd8:  begin s_a0 = r_m[0]; s_a1 = r_m[4]; s_b0 = r_m[1]; s_b1 = r_m[3]; end
            5'd9:  begin s_x = r_m[0]; s_adj = r_adj[0]; end
            5'd10: begin s_x = r_m[1]; s_adj = r_adj[3]; end
            5'd11: begin s_x = r_m[2]; s_adj = r_adj[6]; end
            5'd12: begin s_x = r_t[0]; s_adj = r_adj[0]; end
            5'd13: begin s_x = r_t[1]; s_adj = r_adj[1]; end
            5'd14: begin s_x = r_t[2]; s_adj = r_adj[2]; end
            5'd15: begin s_x = r_t[0]; s_adj = r_adj[3]; end
            5'd16: begin s_x = r_t[1]; s_adj = r_adj[4]; end
            5'd17: begin s_x = r_t[2]; s_adj = r_adj[5]; end
            5'd18: begin s_x = r_t[0]; s_adj = r_adj[6]; end
            5'd19: begin s_x = r_t[1]; s_adj = r_adj[7]; end
            5'd20: begin s_x = r_t[2]; s_adj = r_adj[8]; end
            default: begin s_x = r_m[0]; end
        endcase
    end

    // Two multipliers: element pairs for the adjugate, then the wide
    // adjugate entry split into a signed high half and an unsigned low half.
    always_comb begin
        if (r_step < 5'(STEP_DET)) begin
            s_opa_x = MW'(s_a0);
            s_opa_y = MW'(s_a1);
            s_opb_x = MW'(s_b0);
            s_opb_y = MW'(s_b1);
        end else begin
            s_opa_x = MW'(s_x);
            s_opa_y = s_adj[AW-1:W];
            s_opb_x = MW'(s_x);
            s_opb_y = $signed({1'b0, s_adj[W-1:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa    <= s_opa_x * s_opa_y;
        r_pb    <= s_opb_x * s_opb_y;
        r_pstep <= r_step;
    end

    // Combine the registered products into the adjugate or an accumulator.
    assign s_diff = r_pa - r_pb;
    assign s_val  = (CW'(r_pa) <<< W) + CW'(r_pb);

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m   <= i_m;
            r_t   <= i_t;
            r_det <= '0;
            for (int i = 0; i < 3; i++) begin
                r_tr[i] <= '0;
            end
        end else if (r_pv) begin
            if (r_pstep < 5'(STEP_DET)) begin
                r_adj[r_pstep[3:0]] <= s_diff[AW-1:0];
            end else if (r_pstep < 5'(STEP_TR)) begin
                r_det <= r_det + s_val;
            end else if (r_pstep < 5'(STEP_TR + 3)) begin
                r_tr[0] <= r_tr[0] + s_val;
            end else if (r_pstep < 5'(STEP_TR + 6)) begin
                r_tr[1] <= r_tr[1] + s_val;
            end else begin
                r_tr[2] <= r_tr[2] + s_val;
            end
        end
    end

    // Pack the request for the queue.
    always_comb begin
        o_job = '0;
        for (int e = 0; e < 9; e++) begin
            o_job[e*AW +: AW] = r_adj[e];
        end
        o_job[9*AW +: CW] = r_det;
        for (int i = 0; i < 3; i++) begin
            o_job[9*AW + (i+1)*CW +: CW] = r_tr[i];
        end
        o_job[f_job_w(W)-1] = (r_det == '0);
    end

endmodule

// File: rtl/ami_queue.sv
// Two-entry request queue between the front and back ends.
module ami_queue import ami_pkg::*; #(
    parameter int DATA_W = f_job_w(ELEM_WIDTH_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("request pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("request popped from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_head_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_empty) |=> (o_data == $past(i_data)))
        else $error("request into an empty queue not at its head");
`endif

endmodule

// File: rtl/ami_div.sv
// One rounding, saturating divider lane, one quotient bit per cycle.
module ami_div import ami_pkg::*; #(
    parameter int W     = ELEM_WIDTH_DEF,
    parameter int NUM_W = 2 * ELEM_WIDTH_DEF,
    parameter int DEN_W = f_acc_w(ELEM_WIDTH_DEF)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    input  logic                    i_flip,
    output logic                    o_done,
    output logic signed [W-1:0]     o_res
);

    localparam int LW = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + W + 4;
    localparam int KW = $clog2(W + 2);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_PREP = 4'b0010,
        L_ITER = 4'b0100,
        L_FIN  = 4'b1000
    } t_lstate;

    t_lstate r_state, n_state;
    logic [KW-1:0] r_k;
    logic          r_done;
    logic [LW-1:0] r_n, r_d, r_rem, r_dsh;
    logic [W+1:0]  r_q;
    logic          r_neg;
    logic signed [W-1:0] r_res;

    logic signed [LW-1:0] s_num_x, s_den_x;
    logic [LW-1:0]        s_nabs, s_dabs;
    logic                 s_ge;
    logic                 s_pos_sat, s_neg_sat;
    logic signed [W-1:0]  s_res;

    assign o_done = r_done;
    assign o_res  = r_res;

    // Magnitudes of numerator and denominator.
    assign s_num_x = i_num;
    assign s_den_x = i_den;
    assign s_nabs  = i_num[NUM_W-1] ? (~s_num_x + LW'(1)) : s_num_x;
    assign s_dabs  = i_den[DEN_W-1] ? (~s_den_x + LW'(1)) : s_den_x;
    assign s_ge    = (r_rem >= r_dsh);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_state = L_PREP;
                end
            end
            L_PREP: n_state = L_ITER;
            L_ITER: begin
                if (r_k == '0) begin
                    n_state = L_FIN;
                end
            end
            L_FIN:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_FIN);
        end
    end

    // Rounded quotient is floor((2n + d) / 2d); its upper bits flag overflow.
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_n   <= s_nabs;
                r_d   <= s_dabs;
                r_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1] ^ i_flip;
            end
            L_PREP: begin
                r_rem <= (r_n << 1) + r_d;
                r_dsh <= r_d << (W + 2);
                r_q   <= '0;
                r_k   <= KW'(W + 1);
            end
            L_ITER: begin
                if (s_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[W:0], s_ge};
                r_dsh <= r_dsh >> 1;
                r_k   <= r_k - KW'(1);
            end
            L_FIN:  r_res <= s_res;
            default: r_res <= s_res;
        endcase
    end

    // Saturate the magnitude and apply the sign.
    assign s_pos_sat = (r_q[W+1:W-1] != '0);
    assign s_neg_sat = (r_q[W+1:W] != '0) || (r_q[W-1] && (r_q[W-2:0] != '0));

    always_comb begin
        if (r_neg) begin
            s_res = s_neg_sat ? $signed({1'b1, {(W-1){1'b0}}})
                              : $signed(~r_q[W-1:0] + W'(1));
        end else begin
            s_res = s_pos_sat ? $signed({1'b0, {(W-1){1'b1}}})
                              : $signed(r_q[W-1:0]);
        end
    end

endmodule

// File: rtl/ami_back.sv
// Back end: divides one inverse row at a time and drives the result strobe.
module ami_back import ami_pkg::*; #(
    parameter int W = ELEM_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [f_job_w(W)-1:0] i_job,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic signed [W-1:0]   o_c0,
    output logic signed [W-1:0]   o_c1,
    output logic signed [W-1:0]   o_c2,
    output logic signed [W-1:0]   o_c3,
    output logic [1:0]            o_row_index,
    output logic                  o_last_row,
    output logic                  o_singular
);

    localparam int AW   = f_adj_w(W);
    localparam int CW   = f_acc_w(W);
    localparam int NB_W = AW + 2 * F;
    localparam int NT_W = CW + F;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_RUN  = 3'b010,
        B_SING = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;
    logic [1:0] r_row, n_row;
    logic       s_go, s_emit, s_sing_row;

    logic signed [AW-1:0]   s_adj [9];
    logic signed [CW-1:0]   s_det;
    logic signed [CW-1:0]   s_tr [3];
    logic                   s_sing;
    logic signed [AW-1:0]   s_sel_adj [3];
    logic signed [CW-1:0]   s_sel_tr;
    logic signed [NB_W-1:0] s_nb [3];
    logic signed [NT_W-1:0] s_nt;
    logic [3:0]             s_done;
    logic signed [W-1:0]    s_res [4];

    logic                r_valid, r_last, r_sing;
    logic [1:0]          r_idx;
    logic signed [W-1:0] r_c [4];

    // Unpack the head request.
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            s_adj[e] = i_job[e*AW +: AW];
        end
        s_det = i_job[9*AW +: CW];
        for (int i = 0; i < 3; i++) begin
            s_tr[i] = i_job[9*AW + (i+1)*CW +: CW];
        end
        s_sing = i_job[f_job_w(W)-1];
    end

    // Row sequencer.
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        s_go       = 1'b0;
        s_emit     = 1'b0;
        s_sing_row = 1'b0;
        o_pop      = 1'b0;
        case (r_state)
            B_IDLE: begin
                n_row = ROW0;
                if (!i_empty) begin
                    if (s_sing) begin
                        n_state = B_SING;
                    end else begin
                        n_state = B_RUN;
                        s_go    = 1'b1;
                    end
                end
            end
            B_RUN: begin
                if (s_done[0]) begin
                    s_emit = 1'b1;
                    if (r_row == LAST_ROW) begin
                        o_pop   = 1'b1;
                        n_row   = ROW0;
                        n_state = B_IDLE;
                    end else begin
                        n_row = r_row + 2'd1;
                        s_go  = 1'b1;
                    end
                end
            end
            B_SING: begin
                s_emit     = 1'b1;
                s_sing_row = 1'b1;
                if (r_row == LAST_ROW) begin
                    o_pop   = 1'b1;
                    n_row   = ROW0;
                    n_state = B_IDLE;
                end else begin
                    n_row = r_row + 2'd1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_row   <= ROW0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_valid <= s_emit;
        end
    end

    // Pick the adjugate row and translation sum for the row being started.
    always_comb begin
        case (n_row)
            ROW1: begin
                s_sel_adj[0] = s_adj[3]; s_sel_adj[1] = s_adj[4]; s_sel_adj[2] = s_adj[5];
                s_sel_tr     = s_tr[1];
            end
            ROW2: begin
                s_sel_adj[0] = s_adj[6]; s_sel_adj[1] = s_adj[7]; s_sel_adj[2] = s_adj[8];
                s_sel_tr     = s_tr[2];
            end
            default: begin
                s_sel_adj[0] = s_adj[0]; s_sel_adj[1] = s_adj[1]; s_sel_adj[2] = s_adj[2];
                s_sel_tr     = s_tr[0];
            end
        endcase
        for (int j = 0; j < 3; j++) begin
            s_nb[j] = $signed({s_sel_adj[j], {(2*F){1'b0}}});
        end
        s_nt = $signed({s_sel_tr, {F{1'b0}}});
    end

    // Three basis lanes and one negated translation lane share the divisor.
    for (genvar g = 0; g < 3; g++) begin : g_basis
        ami_div #(.W(W), .NUM_W(NB_W), .DEN_W(CW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (s_go),
            .i_num   (s_nb[g]),
            .i_den   (s_det),
            .i_flip  (1'b0),
            .o_done  (s_done[g]),
            .o_res   (s_res[g])
        );
    end

    ami_div #(.W(W), .NUM_W(NT_W), .DEN_W(CW)) u_div_tr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_go),
        .i_num   (s_nt),
        .i_den   (s_det),
        .i_flip  (1'b1),
        .o_done  (s_done[3]),
        .o_res   (s_res[3])
    );

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            for (int j = 0; j < 4; j++) begin
                r_c[j] <= s_sing_row ? '0 : s_res[j];
            end
            r_idx  <= r_row;
            r_last <= (r_row == LAST_ROW);
            r_sing <= s_sing_row;
        end
    end

    assign o_valid     = r_valid;
    assign o_c0        = r_c[0];
    assign o_c1        = r_c[1];
    assign o_c2        = r_c[2];
    assign o_c3        = r_c[3];
    assign o_row_index = r_idx;
    assign o_last_row  = r_last;
    assign o_singular  = r_sing;

`ifndef NO_ASSERTIONS
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_c0 == '0 && o_c1 == '0 && o_c2 == '0 && o_c3 == '0))
        else $error("singular row carries non-zero values");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == LAST_ROW)))
        else $error("last row flag disagrees with row index");
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_valid && o_last_row))
        else $error("request retired without its final row");
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done[0] |-> (s_done == 4'b1111))
        else $error("divider lanes out of step");
`endif

endmodule

// File: rtl/affine_matrix_inverse.sv
// Affine 3x4 transform inverse: top level joining the front end, queue and back end.
//
// Usage: drive the twelve signed fixed-point elements of a transform and raise
// start; the request is taken at a rising edge where start is high and busy is
// low. Every request gives three result rows, 0, 1 and 2 in order, each shown
// for exactly one cycle with o_valid high; the receiver cannot hold them off.
// o_singular marks a transform whose basis determinant is zero, with zero rows.
// The front end forms the adjugate, determinant and translation sums on two
// shared multipliers, then hands the request to a two-entry queue, so busy
// falls again while earlier requests are dividing. The back end runs four
// restoring divider lanes, one quotient bit per cycle, on one row at a time;
// in its idle state it picks up the next request from the queue, and it pops
// a request only when its last row is given. A singular transform gives its
// zero rows without dividing. Reset is synchronous and active low; it empties
// the queue and returns both ends to idle, dropping any request in flight.
module affine_matrix_inverse import ami_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] i_r0_x,
    input  logic signed [ELEM_WIDTH-1:0] i_r0_y,
    input  logic signed [ELEM_WIDTH-1:0] i_r0_z,
    input  logic signed [ELEM_WIDTH-1:0] i_r0_t,
    input  logic signed [ELEM_WIDTH-1:0] i_r1_x,
    input  logic signed [ELEM_WIDTH-1:0] i_r1_y,
    input  logic signed [ELEM_WIDTH-1:0] i_r1_z,
    input  logic signed [ELEM_WIDTH-1:0] i_r1_t,
    input  logic signed [ELEM_WIDTH-1:0] i_r2_x,
    input  logic signed [ELEM_WIDTH-1:0] i_r2_y,
    input  logic signed [ELEM_WIDTH-1:0] i_r2_z,
    input  logic signed [ELEM_WIDTH-1:0] i_r2_t,
    output logic                         o_valid,
    output logic signed [ELEM_WIDTH-1:0] o_out_c0,
    output logic signed [ELEM_WIDTH-1:0] o_out_c1,
    output logic signed [ELEM_WIDTH-1:0] o_out_c2,
    output logic signed [ELEM_WIDTH-1:0] o_out_c3,
    output logic [1:0]                   o_row_index,
    output logic                         o_last_row,
    output logic                         o_singular
);

    localparam int JW = f_job_w(ELEM_WIDTH);

    logic signed [ELEM_WIDTH-1:0] s_m [9];
    logic signed [ELEM_WIDTH-1:0] s_t [3];
    logic          s_push, s_full, s_pop, s_empty;
    logic [JW-1:0] s_job_in, s_job_out;

    // Gather the basis and translation columns.
    assign s_m[0] = i_r0_x;
    assign s_m[1] = i_r0_y;
    assign s_m[2] = i_r0_z;
    assign s_m[3] = i_r1_x;
    assign s_m[4] = i_r1_y;
    assign s_m[5] = i_r1_z;
    assign s_m[6] = i_r2_x;
    assign s_m[7] = i_r2_y;
    assign s_m[8] = i_r2_z;
    assign s_t[0] = i_r0_t;
    assign s_t[1] = i_r1_t;
    assign s_t[2] = i_r2_t;

    ami_front #(.W(ELEM_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_m     (s_m),
        .i_t     (s_t),
        .o_push  (s_push),
        .o_job   (s_job_in),
        .i_full  (s_full)
    );

    ami_queue #(.DATA_W(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_job_in),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_data  (s_job_out),
        .o_empty (s_empty)
    );

    ami_back #(.W(ELEM_WIDTH), .F(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (s_job_out),
        .i_empty     (s_empty),
        .o_pop       (s_pop),
        .o_valid     (o_valid),
        .o_c0        (o_out_c0),
        .o_c1        (o_out_c1),
        .o_c2        (o_out_c2),
        .o_c3        (o_out_c3),
        .o_row_index (o_row_index),
        .o_last_row  (o_last_row),
        .o_singular  (o_singular)
    );

endmodule

// File: tb/tb_affine_matrix_inverse.sv
// Self-checking testbench for the affine 3x4 transform inverse: directed table, then random transforms.
module tb_affine_matrix_inverse;
    import ami_pkg::*;

    localparam int          EW       = ELEM_WIDTH_DEF;
    localparam int          FB       = FRAC_BITS_DEF;
    localparam logic [31:0] Q_ONE    = 32'h0001_0000;
    localparam logic [31:0] E_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] E_MIN    = 32'h8000_0000;
    localparam int          LIMIT    = 600000;
    localparam int          N_RANDOM = 260;

    // How a directed row is checked.
    typedef enum logic [1:0] {CHK_PREDICT, CHK_IDENTITY, CHK_SINGULAR} chk_e;

    typedef logic [11:0][EW-1:0] mat_t;

    typedef struct {
        logic signed [EW-1:0] c0, c1, c2, c3;
        logic [1:0]           row;
        logic                 last;
        logic                 sing;
    } inv_row_t;

    typedef struct {
        chk_e kind;
        mat_t el;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    mat_t req_el = '0;
    logic o_valid;
    logic signed [EW-1:0] o_out_c0, o_out_c1, o_out_c2, o_out_c3;
    logic [1:0] o_row_index;
    logic o_last_row, o_singular;

    inv_row_t pending_rows[$];
    dir_row_t dir_tab[$];
    int       n_errors = 0;
    int       n_cycles = 0;

    affine_matrix_inverse u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_r0_x      (req_el[0]),
        .i_r0_y      (req_el[1]),
        .i_r0_z      (req_el[2]),
        .i_r0_t      (req_el[3]),
        .i_r1_x      (req_el[4]),
        .i_r1_y      (req_el[5]),
        .i_r1_z      (req_el[6]),
        .i_r1_t      (req_el[7]),
        .i_r2_x      (req_el[8]),
        .i_r2_y      (req_el[9]),
        .i_r2_z      (req_el[10]),
        .i_r2_t      (req_el[11]),
        .o_valid     (o_valid),
        .o_out_c0    (o_out_c0),
        .o_out_c1    (o_out_c1),
        .o_out_c2    (o_out_c2),
        .o_out_c3    (o_out_c3),
        .o_row_index (o_row_index),
        .o_last_row  (o_last_row),
        .o_singular  (o_singular)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Run limit: stop a hung run.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [EW-1:0] got,
                                   input logic [EW-1:0] want);
        $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, n_cycles);
        n_errors++;
    endtask

    // Rounded quotient, ties away from zero, saturated to the element range.
    function automatic logic [EW-1:0] round_div_sat(input logic signed [255:0] num,
                                                    input logic signed [255:0] den);
        logic [255:0] n, d, q;
        logic         neg;
        neg = num[255] ^ den[255];
        n = num[255] ? (~num + 256'd1) : num;
        d = den[255] ? (~den + 256'd1) : den;
        q = ((n << 1) + d) / (d << 1);
        if (!neg)
            return (q > 256'h7FFF_FFFF) ? E_MAX : q[EW-1:0];
        return (q > 256'h8000_0000) ? E_MIN : (~q[EW-1:0] + 1'b1);
    endfunction

    // Inverse of one transform: adjugate over the determinant, exact until one rounding.
    task automatic predict_inverse(input mat_t el);
        logic signed [255:0] m[3][3], t[3], adj[3][3], det, tr;
        inv_row_t            r;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                m[i][j] = {{(256-EW){el[i*4+j][EW-1]}}, el[i*4+j]};
            t[i] = {{(256-EW){el[i*4+3][EW-1]}}, el[i*4+3]};
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                adj[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
                          - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
        det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
        for (int i = 0; i < 3; i++) begin
            r = '{default: '0};
            r.row  = 2'(i);
            r.last = (2'(i) == LAST_ROW);
            r.sing = (det == 0);
            if (!r.sing) begin
                tr = adj[i][0] * t[0] + adj[i][1] * t[1] + adj[i][2] * t[2];
                r.c0 = round_div_sat(adj[i][0] <<< (2 * FB), det);
                r.c1 = round_div_sat(adj[i][1] <<< (2 * FB), det);
                r.c2 = round_div_sat(adj[i][2] <<< (2 * FB), det);
                r.c3 = round_div_sat((-tr) <<< FB, det);
            end
            pending_rows.push_back(r);
        end
    endtask

    // Typed-in rows for the identity basis and for singular transforms.
    task automatic push_known(input chk_e kind, input mat_t el);
        inv_row_t r;
        for (int i = 0; i < 3; i++) begin
            r = '{default: '0};
            r.row  = 2'(i);
            r.last = (2'(i) == LAST_ROW);
            if (kind == CHK_SINGULAR) begin
                r.sing = 1'b1;
            end else begin
                r.c0 = (i == 0) ? Q_ONE : '0;
                r.c1 = (i == 1) ? Q_ONE : '0;
                r.c2 = (i == 2) ? Q_ONE : '0;
                r.c3 = -el[i*4+3];
            end
            pending_rows.push_back(r);
        end
    endtask

    function automatic mat_t mk(input logic [EW-1:0] a0, a1, a2, a3, b0, b1, b2, b3,
                                c0, c1, c2, c3);
        mat_t v;
        v = {c3, c2, c1, c0, b3, b2, b1, b0, a3, a2, a1, a0};
        return v;
    endfunction

    // Present one request and hold it until it is taken.
    task automatic send_request(input mat_t el, input chk_e kind);
        start  <= 1'b1;
        req_el <= el;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == CHK_PREDICT) predict_inverse(el);
        else push_known(kind, el);
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    function automatic logic [EW-1:0] small_elem();
        return EW'($signed($urandom_range(0, 65535)) - 32768);
    endfunction

    // Random transforms: mostly well conditioned, some small, some full range, some singular.
    function automatic mat_t random_matrix();
        mat_t el;
        int   mode;
        mode = $urandom_range(99);
        for (int k = 0; k < 12; k++) el[k] = $urandom();
        if (mode < 55) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    el[i*4+j] = (i == j) ? ($urandom_range(1) ? Q_ONE : -Q_ONE)
                                           + (small_elem() <<< $urandom_range(4))
                                         : small_elem() <<< $urandom_range(3);
        end else if (mode < 70) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    el[i*4+j] = small_elem() >>> $urandom_range(15);
        end else if (mode < 85) begin
            // Singular: repeated row, zero column or zero row.
            case ($urandom_range(2))
                0: begin el[8] = el[0]; el[9] = el[1]; el[10] = el[2]; end
                1: begin el[1] = '0; el[5] = '0; el[9] = '0; end
                default: begin el[4] = '0; el[5] = '0; el[6] = '0; end
            endcase
        end
        return el;
    endfunction

    // Result checker: every strobed row against the oldest expectation.
    always @(posedge i_clk) begin
        inv_row_t w;
        if (i_rst_n && o_valid) begin
            if (pending_rows.size() == 0) begin
                $display("unexpected row %0d at cycle %0d", o_row_index, n_cycles);
                n_errors++;
            end else begin
                w = pending_rows.pop_front();
                if (o_out_c0 !== w.c0) report_mismatch("out_c0", o_out_c0, w.c0);
                if (o_out_c1 !== w.c1) report_mismatch("out_c1", o_out_c1, w.c1);
                if (o_out_c2 !== w.c2) report_mismatch("out_c2", o_out_c2, w.c2);
                if (o_out_c3 !== w.c3) report_mismatch("out_c3", o_out_c3, w.c3);
                if (o_row_index !== w.row)
                    report_mismatch("row_index", EW'(o_row_index), EW'(w.row));
                if (o_last_row !== w.last)
                    report_mismatch("last_row", EW'(o_last_row), EW'(w.last));
                if (o_singular !== w.sing)
                    report_mismatch("singular", EW'(o_singular), EW'(w.sing));
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin
        int pct;
        dir_tab.push_back('{CHK_IDENTITY, mk(Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0, 0, 0, Q_ONE, 0)});
        dir_tab.push_back('{CHK_IDENTITY, mk(Q_ONE, 0, 0, Q_ONE, 0, Q_ONE, 0, -2 * Q_ONE,
                                             0, 0, Q_ONE, 32'h0003_8000)});
        dir_tab.push_back('{CHK_SINGULAR, mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{CHK_SINGULAR, mk(E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX,
                                             E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX)});
        dir_tab.push_back('{CHK_SINGULAR, mk(E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN,
                                             E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN)});
        dir_tab.push_back('{CHK_SINGULAR, mk(3, 5, 7, E_MAX, 1, 2, 9, 4, 3, 5, 7, E_MIN)});
        dir_tab.push_back('{CHK_PREDICT, mk(E_MIN, 0, 0, E_MAX, 0, E_MIN, 0, E_MAX,
                                            0, 0, E_MIN, E_MAX)});
        dir_tab.push_back('{CHK_PREDICT, mk(E_MAX, 0, 0, E_MIN, 0, E_MAX, 0, E_MIN,
                                            0, 0, E_MAX, E_MIN)});
        dir_tab.push_back('{CHK_PREDICT, mk(1, 0, 0, 1, 0, 1, 0, -1, 0, 0, 1, 0)});
        dir_tab.push_back('{CHK_PREDICT, mk(32'h0100_0000, 0, 0, Q_ONE, 0, 32'h0100_0000, 0,
                                            0, 0, 0, 32'h0100_0000, -Q_ONE)});
        dir_tab.push_back('{CHK_PREDICT, mk(0, Q_ONE, 0, 5, 0, 0, Q_ONE, 7, Q_ONE, 0, 0, 9)});
        dir_tab.push_back('{CHK_PREDICT, mk(E_MAX, E_MIN, E_MAX, E_MIN, E_MIN, E_MAX, E_MAX,
                                            E_MAX, E_MAX, E_MAX, E_MIN, E_MIN)});
        dir_tab.push_back('{CHK_PREDICT, mk(-Q_ONE, 0, 0, 3, 0, -Q_ONE, 0, -3,
                                            0, 0, -Q_ONE, E_MIN)});
        dir_tab.push_back('{CHK_PREDICT, mk(32'h5555_5555, 32'hAAAA_AAAA, 0, 32'h5555_5555,
                                            0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                            32'hAAAA_AAAA, 0, 32'h5555_5555, 1)});
        dir_tab.push_back('{CHK_PREDICT, mk(2 * Q_ONE, Q_ONE, 0, 10, Q_ONE, 3 * Q_ONE, Q_ONE,
                                            -20, 0, Q_ONE, 4 * Q_ONE, 30)});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) send_request(dir_tab[k].el, dir_tab[k].kind);

        // Hold off until the directed rows have all come back.
        start <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);

        for (int k = 0; k < N_RANDOM; k++) begin
            case (k * 4 / N_RANDOM)
                0: pct = 0;
                1: pct = 75;
                2: pct = 0;
                default: pct = 24;
            endcase
            send_request(random_matrix(), CHK_PREDICT);
            sender_gap(pct);
        end
        start <= 1'b0;

        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
